>>> rtl/mmlq_pkg.sv
// Package for the min/max linear quantizer: widths, command codes, sequencer states.
// No dependencies.
package mmlq_pkg;
    localparam int CODE_BITS   = 16;
    localparam int SAMPLE_BITS = 20;
    localparam int MAX_SAMPLES = 1048576;
    localparam int CNT_W       = 21;
    localparam int SUM_W       = 41;
    localparam int SQ_W        = 59;
    localparam int DIV_W       = 64;
    localparam int STEP_W      = 7;
    localparam logic [CODE_BITS-1:0] SPAN = CODE_BITS'((1 << CODE_BITS) - 2);
    localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'((1 << (CODE_BITS - 1)) - 1);
    localparam logic [CODE_BITS-1:0] RSV_SIGNED = CODE_BITS'(1 << (CODE_BITS - 1));

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_PACK   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN, ST_MEANW, ST_SQ1, ST_SQ2, ST_VAR, ST_VARW,
        ST_ROOT, ST_PACKMUL, ST_PACKDIV, ST_PACKW, ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]             command;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic                   result_kind;
        logic [CODE_BITS-1:0]   code;
        logic [SAMPLE_BITS-1:0] stat_min;
        logic [SAMPLE_BITS-1:0] stat_max;
        logic [SAMPLE_BITS-1:0] stat_mean;
        logic [SAMPLE_BITS-1:0] stat_stddev;
        logic [CNT_W-1:0]       sample_count;
        logic                   signed_mode;
        logic [CODE_BITS-1:0]   reserved_code;
        logic                   error;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;
endpackage

>>> rtl/mmlq_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on mmlq_pkg.
interface mmlq_in_if (input logic i_clk);
    logic valid;
    logic ready;
    mmlq_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mmlq_out_if (input logic i_clk);
    logic valid;
    logic ready;
    mmlq_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/mmlq_div.sv
// Shared restoring divider, one quotient bit per cycle, 64-bit unsigned operands.
// Depends on mmlq_pkg.
module mmlq_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mmlq_pkg::t_div_req i_req,
    output mmlq_pkg::t_div_rsp o_rsp
);
    import mmlq_pkg::*;
    logic [DIV_W-1:0]  r_quo, r_den, n_quo;
    logic [DIV_W:0]    r_rem, n_rem, w_sh;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;

    always_comb begin
        w_sh  = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        n_quo = {r_quo[DIV_W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[DIV_W-1:0];
endmodule

>>> rtl/mmlq_sqrt.sv
// Iterative integer square root, one result bit per cycle over a 64-bit radicand.
// Depends on mmlq_pkg.
module mmlq_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [63:0]           i_val,
    output logic                  o_done,
    output logic [31:0]           o_root
);
    import mmlq_pkg::*;
    logic [63:0] r_v, r_res, r_bit, w_t;
    logic        r_busy, r_done;

    assign w_t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_val;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_v >= w_t) begin
                    r_v   <= r_v - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

>>> rtl/min_max_linear_quantizer.sv
// Min/max linear quantizer top level: accumulators, sequencer and result registers.
// Clear and accumulate beats keep the sequencer idle. A finish beat runs three 64-step divides
// (mean, square, variance) and a 32-step root; an empty count gives an error. A dividing pack
// runs PACKMUL, PACKDIV and a divide; an error or constant pack goes straight to output.
// A waiting result does not block input; a newer result waits for the slot. Synchronous
// active-low reset clears all statistics. Depends on mmlq_pkg, mmlq_if, mmlq_div, mmlq_sqrt.
module min_max_linear_quantizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmlq_in_if.sink    i_in,
    mmlq_out_if.source o_out
);
    import mmlq_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_min, r_max, r_x;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_drop, r_fin, r_neg;
    logic [CNT_W-1:0]       r_qu, r_ru;
    logic [DIV_W-1:0]       r_c, r_num, r_den;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic                   r_ovalid, n_ovalid;
    t_out                   r_out, r_res, n_res;
    t_div_req               w_req;
    t_div_rsp               w_rsp;
    logic                   w_sq_start, w_sq_done;
    logic [31:0]            w_root;
    logic                   w_acc, w_post;
    t_cmd                   w_cmd;
    logic signed [SAMPLE_BITS-1:0]   w_x;
    logic signed [2*SAMPLE_BITS-1:0] w_xx;
    logic signed [SAMPLE_BITS:0]     w_d;
    logic signed [SAMPLE_BITS+1:0]   w_off;
    logic [SAMPLE_BITS+1:0] w_mag;
    logic [CODE_BITS-1:0]   w_k;
    logic [CODE_BITS+SAMPLE_BITS+1:0] w_pm;
    logic [SUM_W-1:0]       w_u;
    logic [SUM_W:0]         w_ur;
    logic [SUM_W+CNT_W:0]   w_qc;
    logic [2*CNT_W-1:0]     w_rr;
    logic [DIV_W-1:0]       w_var;
    logic signed [DIV_W:0]  w_q, w_lim, w_span;

    mmlq_div u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));
    mmlq_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sq_start), .i_val(w_rsp.quo),
        .o_done(w_sq_done), .o_root(w_root));

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_cmd  = t_cmd'(i_in.payload.command);
    assign w_x    = signed'(i_in.payload.sample);
    assign w_xx   = w_x * w_x;
    assign w_d    = (SAMPLE_BITS+1)'(r_max) - (SAMPLE_BITS+1)'(r_min);
    assign w_u    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_ur   = (SUM_W+1)'(w_u) + (SUM_W+1)'(r_ru);
    assign w_qc   = r_qu * w_ur;
    assign w_rr   = r_ru * r_ru;
    assign w_var  = (DIV_W'(r_sq) >= r_c) ? DIV_W'(r_sq) - r_c : '0;
    assign w_off  = r_neg ? (SAMPLE_BITS+2)'(2 * 32'(signed'(r_x)) - r_max - r_min)
                          : (SAMPLE_BITS+2)'(r_x) - (SAMPLE_BITS+2)'(r_min);
    assign w_mag  = w_off[SAMPLE_BITS+1] ? (SAMPLE_BITS+2)'(-w_off)
                                         : (SAMPLE_BITS+2)'(w_off);
    assign w_k    = r_neg ? HALF : SPAN;
    assign w_pm   = w_k * w_mag;
    assign w_q    = r_neg ? -(DIV_W+1)'(w_rsp.quo) : (DIV_W+1)'(w_rsp.quo);
    assign w_lim  = signed'((DIV_W+1)'(HALF));
    assign w_span = signed'((DIV_W+1)'(SPAN));
    assign w_post = (r_state == ST_OUT) && (!r_ovalid || o_out.ready);
    assign n_ovalid = w_post || (r_ovalid && !o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_cmd == CMD_FINISH) begin
                    n_state = (r_cnt == '0) ? ST_OUT : ST_MEAN;
                end else if (w_acc && w_cmd == CMD_PACK) begin
                    n_state = (!r_fin || w_d == '0) ? ST_OUT : ST_PACKMUL;
                end
            end
            ST_MEAN:    n_state = ST_MEANW;
            ST_MEANW:   if (w_rsp.done) n_state = ST_SQ1;
            ST_SQ1:     n_state = ST_SQ2;
            ST_SQ2:     if (w_rsp.done) n_state = ST_VAR;
            ST_VAR:     n_state = ST_VARW;
            ST_VARW:    if (w_rsp.done) n_state = ST_ROOT;
            ST_ROOT:    if (w_sq_done) n_state = ST_OUT;
            ST_PACKMUL: n_state = ST_PACKDIV;
            ST_PACKDIV: n_state = ST_PACKW;
            ST_PACKW:   if (w_rsp.done) n_state = ST_OUT;
            ST_OUT:     if (w_post) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_req      = '0;
        w_sq_start = 1'b0;
        case (r_state)
            ST_MEAN: begin
                w_req.start = 1'b1;
                w_req.num   = DIV_W'(w_u);
                w_req.den   = DIV_W'(r_cnt);
            end
            ST_SQ1: begin
                w_req.start = 1'b1;
                w_req.num   = DIV_W'(w_rr) + DIV_W'(r_cnt) - DIV_W'(1);
                w_req.den   = DIV_W'(r_cnt);
            end
            ST_VAR: begin
                w_req.start = 1'b1;
                w_req.num   = w_var;
                w_req.den   = DIV_W'(r_cnt);
            end
            ST_PACKDIV: begin
                w_req.start = 1'b1;
                w_req.num   = r_num;
                w_req.den   = r_den;
            end
            default: begin
                w_req = '0;
            end
        endcase
        if (r_state == ST_VARW && w_rsp.done) w_sq_start = 1'b1;
    end

    always_comb begin
        n_res = r_res;
        if (w_acc && w_cmd == CMD_FINISH) begin
            n_res = '0;
            n_res.result_kind = 1'b1;
            n_res.error = 1'b1;
        end else if (w_acc && w_cmd == CMD_PACK) begin
            n_res = '0;
            if (!r_fin) begin
                n_res.error = 1'b1;
            end else if (r_min < 0) begin
                n_res.signed_mode   = 1'b1;
                n_res.reserved_code = RSV_SIGNED;
            end else begin
                n_res.code = CODE_BITS'(1);
            end
        end
        case (r_state)
            ST_PACKW: if (w_rsp.done) begin
                n_res = '0;
                if (r_min < 0) begin
                    n_res.signed_mode   = 1'b1;
                    n_res.reserved_code = RSV_SIGNED;
                    if (w_q > w_lim)
                        n_res.code = HALF;
                    else if (w_q < -w_lim)
                        n_res.code = -HALF;
                    else
                        n_res.code = CODE_BITS'(w_q);
                end else begin
                    if (w_q < 0)
                        n_res.code = CODE_BITS'(1);
                    else if (w_q > w_span)
                        n_res.code = SPAN + 1'b1;
                    else
                        n_res.code = CODE_BITS'(w_q) + 1'b1;
                end
            end
            ST_ROOT: if (w_sq_done) begin
                n_res.result_kind   = 1'b1;
                n_res.code          = '0;
                n_res.stat_min      = r_min;
                n_res.stat_max      = r_max;
                n_res.stat_mean     = r_mean;
                n_res.stat_stddev   = SAMPLE_BITS'(w_root);
                n_res.sample_count  = r_cnt;
                n_res.signed_mode   = r_min < 0;
                n_res.reserved_code = (r_min < 0) ? RSV_SIGNED : '0;
                n_res.error         = r_drop;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_drop   <= 1'b0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
            r_res    <= '0;
            r_out    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_res    <= n_res;
            if (w_post) r_out <= r_res;
            if (w_acc) begin
                r_x <= w_x;
                case (w_cmd)
                    CMD_CLEAR: begin
                        r_cnt  <= '0;
                        r_min  <= '0;
                        r_max  <= '0;
                        r_sum  <= '0;
                        r_sq   <= '0;
                        r_drop <= 1'b0;
                        r_fin  <= 1'b0;
                    end
                    CMD_ACCUM: begin
                        r_fin <= 1'b0;
                        if (r_cnt >= CNT_W'(MAX_SAMPLES)) begin
                            r_drop <= 1'b1;
                        end else begin
                            if (r_cnt == '0 || w_x < r_min) r_min <= w_x;
                            if (r_cnt == '0 || w_x > r_max) r_max <= w_x;
                            r_sum <= r_sum + SUM_W'(w_x);
                            r_sq  <= r_sq + SQ_W'(w_xx);
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    CMD_PACK: r_neg <= r_min < 0;
                    default: ;
                endcase
            end
            case (r_state)
                ST_MEANW: if (w_rsp.done) begin
                    r_qu <= CNT_W'(w_rsp.quo);
                    r_ru <= CNT_W'(w_rsp.rem);
                    if (r_sum < 0)
                        r_mean <= SAMPLE_BITS'(-w_rsp.quo - DIV_W'(w_rsp.rem != '0));
                    else
                        r_mean <= SAMPLE_BITS'(w_rsp.quo);
                end
                ST_SQ1: r_c <= DIV_W'(w_qc);
                ST_SQ2: if (w_rsp.done) r_c <= r_c + w_rsp.quo;
                ST_ROOT: if (w_sq_done) r_fin <= 1'b1;
                ST_PACKMUL: begin
                    r_num <= DIV_W'({w_pm, 1'b0}) + DIV_W'(unsigned'(w_d));
                    r_den <= DIV_W'({unsigned'(w_d), 1'b0});
                    r_neg <= w_off[SAMPLE_BITS+1];
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_post |=> r_ovalid)
        else $error("result not posted");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_out)))
        else $error("result dropped");
endmodule
